// ===== design/color_histogram_engine_assert.svh =====
// Assertion macros used by the checker file of the histogram engine.
`ifndef COLOR_HISTOGRAM_ENGINE_ASSERT_SVH
`define COLOR_HISTOGRAM_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram engine check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram engine check failed");

`endif

// ===== design/che_pkg.sv =====
package che_pkg;

    localparam int MAX_BINS    = 4096;
    localparam int BIN_AW      = 12;
    localparam int COUNT_BITS  = 24;
    localparam int IDX_BITS    = 25;
    localparam int FRAC_BITS   = 17;
    localparam int FDIV_BITS   = COUNT_BITS + 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0]  FRAC_ONE  = 17'd65536;

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] CFG_BIN_SIZE  = 2'd0;
    localparam logic [1:0] CFG_PIXEL_MAX = 2'd1;
    localparam logic [1:0] CFG_CHANNELS  = 2'd2;
    localparam logic [1:0] CFG_NORMALIZE = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  sample_a;
        logic [7:0]  sample_b;
        logic [7:0]  sample_c;
        logic [11:0] read_bin;
    } in_item_t;

    typedef struct packed {
        logic [11:0] bin_index;
        logic [23:0] bin_count;
        logic [16:0] fraction;
        logic        out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [8:0] bin_size;
        logic [7:0] pixel_max;
        logic [1:0] channel_count;
        logic       normalize;
    } cfg_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic [1:0]        kind;
        logic [BIN_AW-1:0] idx;
        logic              oor;
    } op_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== design/che_fifo.sv =====
module che_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  che_pkg::op_t   push_op,
    input  logic           pop,
    output che_pkg::op_t   head,
    output logic           full,
    output logic           empty
);

    che_pkg::op_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/che_front.sv =====
module che_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  che_pkg::cfg_t         cfg,
    input  che_pkg::back_status_t status,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  che_pkg::in_item_t     in_data,
    output logic                  push,
    output che_pkg::op_t          push_op,
    input  logic                  full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_BPC  = 3'd1;
    localparam logic [2:0] F_QDIV = 3'd2;
    localparam logic [2:0] F_MACC = 3'd3;
    localparam logic [2:0] F_WMUL = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    logic [2:0]                     state_reg, state_next;
    che_pkg::in_item_t              item_reg;
    che_pkg::op_t                   op_reg, op_next;
    logic [9:0]                     rem_reg, rem_next;
    logic [8:0]                     quo_reg, quo_next;
    logic [3:0]                     cnt_reg, cnt_next;
    logic [8:0]                     bpc_reg, bpc_next;
    logic [1:0]                     ch_reg, ch_next;
    logic [che_pkg::IDX_BITS-1:0]   idx_reg, idx_next;
    logic [16:0]                    w_reg, w_next;
    logic [7:0]                     q_reg, q_next;

    logic [8:0]  bs;
    logic [1:0]  nch;
    logic [9:0]  rem_sh;
    logic        ge;
    logic [9:0]  rem_step;
    logic [8:0]  quo_step;
    logic [7:0]  next_sample;
    logic [che_pkg::IDX_BITS-1:0] idx_sum;
    logic [25:0] w_prod;
    logic        accept;

    assign bs  = (cfg.bin_size == 9'd0) ? 9'd1 : cfg.bin_size;
    assign nch = (cfg.channel_count == 2'd0) ? 2'd1 : cfg.channel_count;

    // One restoring step of the shared quotient unit.
    assign rem_sh   = {rem_reg[8:0], quo_reg[8]};
    assign ge       = (rem_sh >= {1'b0, bs});
    assign rem_step = ge ? (rem_sh - {1'b0, bs}) : rem_sh;
    assign quo_step = {quo_reg[7:0], ge};

    assign idx_sum = idx_reg + che_pkg::IDX_BITS'(q_reg) * che_pkg::IDX_BITS'(w_reg);
    assign w_prod  = w_reg * bpc_reg;

    // Sample of the channel that follows the current one.
    always_comb
    begin
        case (ch_reg)
            2'd0:    next_sample = item_reg.sample_b;
            2'd1:    next_sample = item_reg.sample_c;
            default: next_sample = 8'd0;
        endcase
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != F_IDLE) || status.clearing;
    assign push     = (state_reg == F_PUSH) && !full;
    assign push_op  = op_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        bpc_next   = bpc_reg;
        ch_next    = ch_reg;
        idx_next   = idx_reg;
        w_next     = w_reg;
        q_next     = q_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_next.kind = in_data.cmd;
                    op_next.idx  = in_data.read_bin;
                    op_next.oor  = 1'b0;
                    if (in_data.cmd == che_pkg::CMD_PIXEL)
                    begin
                        rem_next   = 10'd0;
                        quo_next   = {1'b0, cfg.pixel_max} + bs;
                        cnt_next   = 4'd0;
                        state_next = F_BPC;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_BPC:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    bpc_next   = quo_step;
                    ch_next    = 2'd0;
                    idx_next   = '0;
                    w_next     = 17'd1;
                    rem_next   = 10'd0;
                    quo_next   = {1'b0, item_reg.sample_a};
                    cnt_next   = 4'd0;
                    state_next = F_QDIV;
                end
            end
            F_QDIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    q_next     = quo_step[7:0];
                    state_next = F_MACC;
                end
            end
            F_MACC:
            begin
                idx_next = idx_sum;
                if (ch_reg == nch - 2'd1)
                begin
                    op_next.oor = (idx_sum >= che_pkg::IDX_BITS'(che_pkg::MAX_BINS));
                    op_next.idx = op_next.oor ? '0 : idx_sum[che_pkg::BIN_AW-1:0];
                    state_next  = F_PUSH;
                end
                else
                begin
                    state_next = F_WMUL;
                end
            end
            F_WMUL:
            begin
                w_next     = w_prod[16:0];
                ch_next    = ch_reg + 2'd1;
                rem_next   = 10'd0;
                quo_next   = {1'b0, next_sample};
                cnt_next   = 4'd0;
                state_next = F_QDIV;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        op_reg  <= op_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        bpc_reg <= bpc_next;
        ch_reg  <= ch_next;
        idx_reg <= idx_next;
        w_reg   <= w_next;
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/che_back.sv =====
module che_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  che_pkg::cfg_t         cfg,
    output che_pkg::back_status_t status,
    input  che_pkg::op_t          head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output che_pkg::out_item_t    out_data
);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_UPD  = 3'd2;
    localparam logic [2:0] B_FDIV = 3'd3;
    localparam logic [2:0] B_DONE = 3'd4;
    localparam logic [2:0] B_CLR  = 3'd5;

    localparam int CB = che_pkg::COUNT_BITS;
    localparam int FB = che_pkg::FDIV_BITS;

    logic [CB-1:0] mem [che_pkg::MAX_BINS];
    logic [CB-1:0] rd_data_reg;

    logic [2:0]                   state_reg, state_next;
    che_pkg::op_t                 op_reg, op_next;
    che_pkg::out_item_t           res_reg, res_next;
    logic [CB-1:0]                total_reg, total_next;
    logic [CB-1:0]                divisor_reg, divisor_next;
    logic [CB:0]                  rem_reg, rem_next;
    logic [FB-1:0]                quo_reg, quo_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic [che_pkg::BIN_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic                         out_valid_reg;
    che_pkg::out_item_t           out_data_reg;

    logic                         mem_we;
    logic [che_pkg::BIN_AW-1:0]   mem_waddr;
    logic [CB-1:0]                mem_wdata;
    logic [CB-1:0]                cnt_new, total_eff;
    logic                         is_pixel;
    logic [CB:0]                  rem_sh, rem_step;
    logic                         ge;
    logic [FB-1:0]                quo_step;
    logic                         load_out;

    assign rem_sh   = {rem_reg[CB-1:0], quo_reg[FB-1]};
    assign ge       = (rem_sh >= {1'b0, divisor_reg});
    assign rem_step = ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
    assign quo_step = {quo_reg[FB-2:0], ge};

    assign is_pixel  = (op_reg.kind == che_pkg::CMD_PIXEL);
    assign cnt_new   = (is_pixel && rd_data_reg != che_pkg::COUNT_MAX) ?
                       rd_data_reg + CB'(1) : rd_data_reg;
    assign total_eff = (is_pixel && total_reg != che_pkg::COUNT_MAX) ?
                       total_reg + CB'(1) : total_reg;

    assign pop             = (state_reg == B_IDLE) && !empty;
    assign load_out        = (state_reg == B_DONE) && (!out_valid_reg || !out_stall);
    assign status.clearing = (state_reg == B_INIT) || (state_reg == B_CLR);
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        res_next      = res_reg;
        total_next    = total_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        unique case (state_reg) inside
            B_INIT, B_CLR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + che_pkg::BIN_AW'(1);
                if (clr_addr_reg == che_pkg::BIN_AW'(che_pkg::MAX_BINS - 1))
                begin
                    total_next = '0;
                    res_next   = '0;
                    state_next = (state_reg == B_CLR) ? B_DONE : B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    op_next  = head;
                    res_next = '0;
                    if (head.kind == che_pkg::CMD_CLEAR)
                    begin
                        clr_addr_next = '0;
                        state_next    = B_CLR;
                    end
                    else if (head.kind == che_pkg::CMD_NONE)
                    begin
                        state_next = B_DONE;
                    end
                    else if (head.oor)
                    begin
                        res_next.out_of_range = 1'b1;
                        state_next            = B_DONE;
                    end
                    else
                    begin
                        state_next = B_UPD;
                    end
                end
            end
            B_UPD:
            begin
                mem_we             = is_pixel;
                mem_waddr          = op_reg.idx;
                mem_wdata          = cnt_new;
                total_next         = total_eff;
                res_next.bin_index = op_reg.idx;
                res_next.bin_count = cnt_new;
                res_next.fraction  = '0;
                if (cfg.normalize && total_eff != '0)
                begin
                    divisor_next = total_eff;
                    rem_next     = '0;
                    quo_next     = {cnt_new, 16'd0};
                    cnt_next     = '0;
                    state_next   = B_FDIV;
                end
                else
                begin
                    state_next = B_DONE;
                end
            end
            B_FDIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FB - 1))
                begin
                    res_next.fraction = (quo_step > FB'(che_pkg::FRAC_ONE)) ?
                                        che_pkg::FRAC_ONE : quo_step[16:0];
                    state_next        = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Count store: one write port, one registered read port addressed by the queue head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head.idx];
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        res_reg     <= res_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            total_reg    <= total_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/color_histogram_engine.sv =====
// Channel | Direction | Payload            | Handshake
// in      | input     | che_pkg::in_item_t  | in_valid / in_stall
// out     | output    | che_pkg::out_item_t | out_valid / out_stall
// cfg     | input     | 9-bit data, 2-bit index | cfg_we, no read-back
//
// A pixel keeps the front busy for the bins-per-channel quotient, then per
// channel a serial 9-step quotient, a multiply-add and a weight multiply
// that the last channel skips, and then one push state, which waits while
// the queue is full.
// A read passes the back's update and done states, plus a serial divide for
// the Q1.16 fraction when normalization is on.
// After reset, and on every clear request, the back sweeps all 4096 count
// entries, one per cycle, and in_stall stays high during the sweep.
// The output register lets the back finish a request while out_stall is high.
module color_histogram_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  che_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output che_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    // Configuration registers; the user must keep writes to times when the engine is idle;
    // the block does not enforce this, and both halves read the registers directly.
    che_pkg::cfg_t         cfg_reg;
    che_pkg::back_status_t status;
    logic                  push, pop, full, empty;
    che_pkg::op_t          push_op, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_size      <= 9'd16;
            cfg_reg.pixel_max     <= 8'd255;
            cfg_reg.channel_count <= 2'd3;
            cfg_reg.normalize     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                che_pkg::CFG_BIN_SIZE:  cfg_reg.bin_size      <= cfg_data;
                che_pkg::CFG_PIXEL_MAX: cfg_reg.pixel_max     <= cfg_data[7:0];
                che_pkg::CFG_CHANNELS:  cfg_reg.channel_count <= cfg_data[1:0];
                che_pkg::CFG_NORMALIZE: cfg_reg.normalize     <= cfg_data[0];
                default:                cfg_reg.normalize     <= cfg_reg.normalize;
            endcase
        end
    end

    // The front classifies each request and computes the joint bin index.
    che_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .status   (status),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_op  (push_op),
        .full     (full)
    );

    // A two-entry queue decouples index computation from the count update.
    che_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    // The back owns the count store, the pixel total and the result register.
    che_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .status    (status),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/che_checker.sv =====
`include "color_histogram_engine_assert.svh"

module che_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input che_pkg::out_item_t out_data
);

    logic oor_fields_zero;

    assign oor_fields_zero = (out_data.bin_index == 12'd0) && (out_data.bin_count == 24'd0) &&
                             (out_data.fraction == 17'd0);

    `CHE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `CHE_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    `CHE_ASSERT_IMP(a_oor_zero, out_valid && out_data.out_of_range, oor_fields_zero)
    `CHE_ASSERT_IMP(a_frac_max, out_valid, out_data.fraction <= che_pkg::FRAC_ONE)

endmodule

bind color_histogram_engine che_checker u_che_checker (.*);
